@@ rtl/core/svs_pkg.sv @@
// Shared types and constants of the sampled victim select unit.
package svs_pkg;

	localparam int INDEX_BITS = 16;
	localparam int TIME_BITS  = 48;
	localparam int COST_BITS  = 32;

	localparam int SC_BITS       = 11;
	localparam int PEN_BITS      = 20;
	localparam int CFG_DATA_BITS = 20;

	localparam logic [SC_BITS-1:0]  SAMPLE_COUNT_RST = SC_BITS'(128);
	localparam logic [PEN_BITS-1:0] PENALTY_RST      = PEN_BITS'(6554);

	// weight = cost * multiplier, saturated to 52 bits (W_BITS, capped at 64)
	localparam int WFULL_BITS = COST_BITS + PEN_BITS;
	localparam int W_BITS     = (WFULL_BITS > 64) ? 64 : WFULL_BITS;

	// second operand of the shared multiplier: a recency or a Q4.16 multiplier
	localparam int MB_BITS = (TIME_BITS > PEN_BITS) ? TIME_BITS : PEN_BITS;

	localparam logic [MB_BITS-1:0] Q16_ONE = MB_BITS'(65536);

	localparam int MUL_DIGIT_BITS = 16;

	typedef enum logic [0:0] {
		CFG_SAMPLE_COUNT = 1'b0,
		CFG_NOREUSE_MULT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]  now_time;
		logic [INDEX_BITS-1:0] cand_index;
		logic                  cand_valid;
		logic [COST_BITS-1:0]  cand_cost;
		logic [TIME_BITS-1:0]  cand_last_access;
		logic                  cand_reused;
	} in_req_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] victim_index;
		logic                  victim_found;
	} out_res_t;

	typedef struct packed {
		logic               start;
		logic [W_BITS-1:0]  a;
		logic [MB_BITS-1:0] b;
	} mul_req_t;

endpackage

@@ rtl/core/svs_mul.sv @@
// Iterative multiplier: one digit of the second operand per cycle.
module svs_mul #(
	parameter int DIGIT_BITS = svs_pkg::MUL_DIGIT_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  svs_pkg::mul_req_t                        cmd,
	output logic                                     done,
	output logic [svs_pkg::W_BITS+((svs_pkg::MB_BITS+DIGIT_BITS-1)/DIGIT_BITS)*DIGIT_BITS-1:0]
	                                                 product
);

	localparam int AW       = svs_pkg::W_BITS;
	localparam int BW       = svs_pkg::MB_BITS;
	localparam int NB       = (BW + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int BPW      = NB * DIGIT_BITS;
	localparam int PW       = AW + BPW;
	localparam int CNT_BITS = $clog2(NB + 1);

	logic [AW-1:0]         a_q;
	logic [BPW-1:0]        b_q;
	logic [PW-1:0]         prod_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [AW+DIGIT_BITS-1:0] pp;
	logic [AW+DIGIT_BITS-1:0] sum;
	logic [PW+DIGIT_BITS-1:0] full;

	// add the partial product into the top and shift the whole product right one digit
	assign pp   = (AW+DIGIT_BITS)'(a_q) * (AW+DIGIT_BITS)'(b_q[DIGIT_BITS-1:0]);
	assign sum  = (AW+DIGIT_BITS)'(prod_q[PW-1 -: AW]) + pp;
	assign full = {sum, prod_q[PW-AW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			cnt_q  <= CNT_BITS'(NB);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q    <= cmd.a;
			b_q    <= BPW'(cmd.b);
			prod_q <= '0;
		end else if (busy_q) begin
			b_q    <= b_q >> DIGIT_BITS;
			prod_q <= full[PW+DIGIT_BITS-1:DIGIT_BITS];
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

@@ rtl/core/sampled_victim_select_unit.sv @@
// Top level: picks the lowest weighted-cost-over-recency sample of each run.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | in_req_t, one sample plus current time
//  res     | out       | res_valid/res_stall | out_res_t, victim of a finished run
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An invalid sample goes straight to the done state. A valid sample runs the shared
// digit-serial multiplier once when it opens the run and three times otherwise (weight,
// then the two cross products), each in NB = ceil(48/MUL_DIGIT_BITS) = 3 digit steps.
// Reset leaves sample_count 128, the no-reuse multiplier 6554 and an empty run.
// A held result only blocks the request that ends the next run.
module sampled_victim_select_unit #(
	parameter int MUL_DIGIT_BITS = svs_pkg::MUL_DIGIT_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  svs_pkg::in_req_t                    req,
	output logic                                res_valid,
	input  logic                                res_stall,
	output svs_pkg::out_res_t                   res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  svs_pkg::cfg_idx_t                   cfg_index,
	input  logic [svs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int NB = (svs_pkg::MB_BITS + MUL_DIGIT_BITS - 1) / MUL_DIGIT_BITS;
	localparam int PW = svs_pkg::W_BITS + NB * MUL_DIGIT_BITS;
	localparam int WB = svs_pkg::W_BITS;
	localparam int TB = svs_pkg::TIME_BITS;
	localparam int SB = svs_pkg::SC_BITS;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_REC  = 6'b000010,
		S_WMUL = 6'b000100,
		S_XL   = 6'b001000,
		S_XR   = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t                           state_q;
	svs_pkg::in_req_t                 item_q;
	logic [TB-1:0]                    rec_q;
	logic [WB-1:0]                    weight_q;
	logic [PW-1:0]                    lprod_q;
	logic [WB-1:0]                    best_weight_q;
	logic [TB-1:0]                    best_rec_q;
	logic [svs_pkg::INDEX_BITS-1:0]   best_slot_q;
	logic                             have_best_q;
	logic [SB-1:0]                    seen_q;
	logic [SB-1:0]                    sample_count_q;
	logic [svs_pkg::PEN_BITS-1:0]     penalty_q;
	svs_pkg::out_res_t                res_q;
	logic                             res_valid_q;

	svs_pkg::mul_req_t                mul_cmd;
	logic                             mul_done;
	logic [PW-1:0]                    mul_prod;

	logic [TB-1:0]                    rec_now;
	logic [WB-1:0]                    weight_now;
	logic [SB-1:0]                    cnt_eff;
	logic [SB:0]                      seen_next;
	logic                             end_run;
	logic                             res_free;
	logic                             res_load;

	svs_mul #(.DIGIT_BITS(MUL_DIGIT_BITS)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mul_cmd),
		.done    (mul_done),
		.product (mul_prod)
	);

	assign rec_now = (item_q.now_time > item_q.cand_last_access) ?
	                 item_q.now_time - item_q.cand_last_access : TB'(1);

	assign weight_now = (|mul_prod[PW-1:WB]) ? '1 : mul_prod[WB-1:0];

	assign cnt_eff   = (sample_count_q == '0) ? SB'(1) : sample_count_q;
	assign seen_next = {1'b0, seen_q} + (SB+1)'(1);
	assign end_run   = seen_next >= {1'b0, cnt_eff};
	assign res_free  = !res_valid_q || !res_stall;
	assign res_load  = (state_q == S_DONE) && end_run && res_free;

	always_comb begin
		mul_cmd.start = 1'b0;
		mul_cmd.a     = WB'(item_q.cand_cost);
		mul_cmd.b     = item_q.cand_reused ? svs_pkg::Q16_ONE
		                                   : svs_pkg::MB_BITS'(penalty_q);
		unique case (state_q)
			S_REC: begin
				mul_cmd.start = 1'b1;
			end
			S_WMUL: begin
				mul_cmd.start = mul_done && have_best_q;
				mul_cmd.a     = weight_now;
				mul_cmd.b     = svs_pkg::MB_BITS'(best_rec_q);
			end
			S_XL: begin
				mul_cmd.start = mul_done;
				mul_cmd.a     = best_weight_q;
				mul_cmd.b     = svs_pkg::MB_BITS'(rec_q);
			end
			default: begin
				mul_cmd.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			best_weight_q <= '0;
			best_rec_q    <= TB'(1);
			best_slot_q   <= '0;
			have_best_q   <= 1'b0;
			seen_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= req.cand_valid ? S_REC : S_DONE;
					end
				end
				S_REC: begin
					state_q <= S_WMUL;
				end
				S_WMUL: begin
					if (mul_done) begin
						if (!have_best_q) begin
							best_weight_q <= weight_now;
							best_rec_q    <= rec_q;
							best_slot_q   <= item_q.cand_index;
							have_best_q   <= 1'b1;
							state_q       <= S_DONE;
						end else begin
							state_q <= S_XL;
						end
					end
				end
				S_XL: begin
					if (mul_done) begin
						state_q <= S_XR;
					end
				end
				S_XR: begin
					if (mul_done) begin
						// strict less-than: on a tie the earlier sample stays
						if (lprod_q < mul_prod) begin
							best_weight_q <= weight_q;
							best_rec_q    <= rec_q;
							best_slot_q   <= item_q.cand_index;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!end_run) begin
						seen_q  <= seen_next[SB-1:0];
						state_q <= S_IDLE;
					end else if (res_free) begin
						best_weight_q <= '0;
						best_rec_q    <= TB'(1);
						best_slot_q   <= '0;
						have_best_q   <= 1'b0;
						seen_q        <= '0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			item_q <= req;
		end
		if (state_q == S_REC) begin
			rec_q <= rec_now;
		end
		if (state_q == S_WMUL && mul_done) begin
			weight_q <= weight_now;
		end
		if (state_q == S_XL && mul_done) begin
			lprod_q <= mul_prod;
		end
		if (res_load) begin
			res_q.victim_index <= have_best_q ? best_slot_q : '0;
			res_q.victim_found <= have_best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= svs_pkg::SAMPLE_COUNT_RST;
			penalty_q      <= svs_pkg::PENALTY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				svs_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[SB-1:0];
				svs_pkg::CFG_NOREUSE_MULT: penalty_q <= cfg_data[svs_pkg::PEN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

	// the multiplier only finishes while the sequencer waits on it
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_WMUL || state_q == S_XL || state_q == S_XR))
		else $error("multiplier finished outside a wait state");

	// cross products are only formed against an existing best sample
	a_cross_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_XL || state_q == S_XR) |-> have_best_q)
		else $error("cross product without a best sample");

	// an empty run keeps the cleared slot
	a_empty_run_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!have_best_q |-> (best_slot_q == '0))
		else $error("best slot set in an empty run");

	// the request that ends a run waits while a finished result is held
	a_end_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && end_run && res_valid_q && res_stall) |=> (state_q == S_DONE))
		else $error("run ended while result was still held");

endmodule
